// ----- rtl/core/lsm_pkg.sv -----
// Shared types, constants and helper functions for the leader suffix matcher.
package lsm_pkg;

  localparam int NUM_LEADERS    = 4;
  localparam int MAX_LEADER_LEN = 22;
  localparam int MAX_TRIM       = 10;
  localparam int POS_W          = 16;
  localparam int BASES_W        = 44;
  localparam int LEN_W          = 5;
  localparam int LEAD_W         = 2;
  localparam int CODE_W         = 3;
  localparam int PADDR_W        = 6;
  localparam int PDATA_W        = 64;

  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;
  localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};

  // Leader length register reset values
  localparam logic [LEN_W-1:0] LEN_RESET [NUM_LEADERS] = '{5'd22, 5'd22, 5'd22, 5'd21};

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_BASES_A = 3'd0,
    REG_BASES_B = 3'd1,
    REG_BASES_C = 3'd2,
    REG_BASES_D = 3'd3,
    REG_LEN_A   = 3'd4,
    REG_LEN_B   = 3'd5,
    REG_LEN_C   = 3'd6,
    REG_LEN_D   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] base_code;
    logic              last_base;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [LEAD_W-1:0] leader_index;
    logic [POS_W-1:0]  start_position;
    logic [LEN_W-1:0]  matched_length;
    logic              overflow;
  } out_item_t;

  // Best match candidate for one trim amount
  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  start;
    logic [LEAD_W-1:0] lead;
  } cand_t;

  localparam cand_t CAND_RESET = '{hit: 1'b0, start: POS_MAX, lead: '0};

  // Control from the top level into each trim cell
  typedef struct packed {
    logic upd;
    logic clr;
  } trim_ctl_t;

  // Leader length clamped to the history depth
  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = (n > LEN_W'(MAX_LEADER_LEN)) ? LEN_W'(MAX_LEADER_LEN) : n;
    return r;
  endfunction

  // Leader base expected at history slot j (slot 0 = newest base)
  function automatic logic [1:0] exp_base(logic [BASES_W-1:0] bases,
                                          logic [LEN_W-1:0] len_e, int j);
    int         idx;
    logic [1:0] r;
    idx = int'(len_e) - 1 - j;
    if (idx < 0 || idx >= MAX_LEADER_LEN) begin
      r = 2'd0;
    end else begin
      r = bases[2*idx +: 2];
    end
    return r;
  endfunction

  // Earlier start wins; on equal start the lower leader wins
  function automatic cand_t better(cand_t a, cand_t b);
    cand_t r;
    if (a.hit && (!b.hit || {a.start, a.lead} <= {b.start, b.lead})) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/leader_suffix_matcher.sv -----
// Top level: config registers, history cell chain, trim cells and result stages.
//
// Input channel (in_valid/in_ready/in_data): one DNA base per request,
// last_base marks the final base of a sequence. One base is taken every cycle
// while in_ready is high; the 22-cell history chain shifts once per request.
// Output channel (out_valid/out_ready/out_data): one result per sequence,
// sent after its last base: earliest match for the smallest trim amount.
// Path: a last base passes the history stage, compare stage, trim
// update/snapshot stage and output register before its result is valid.
// Throughput: one base per cycle unless stalled, set by the single chain shift.
// Stalls: a waiting result sits in the output register, a second one in the
// snapshot register; bases keep flowing until a third last base reaches the
// compare stage, then in_ready drops until the output is taken.
// Reset: history cells read "other", counter and per-trim state clear, leader
// registers go to zero bases and lengths 22, 22, 22, 21. Config: APB write at
// 8*index, written only while the block is idle: a user rule, not enforced.
module leader_suffix_matcher import lsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  // Output channel
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [BASES_W-1:0] lead_bases_r [NUM_LEADERS];
  logic [LEN_W-1:0]   lead_len_r   [NUM_LEADERS];
  logic [LEN_W-1:0]   len_e        [NUM_LEADERS];
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEADERS; l++) begin
        lead_bases_r[l] <= '0;
        lead_len_r[l]   <= LEN_RESET[l];
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASES_A: lead_bases_r[0] <= pwdata[BASES_W-1:0];
        REG_BASES_B: lead_bases_r[1] <= pwdata[BASES_W-1:0];
        REG_BASES_C: lead_bases_r[2] <= pwdata[BASES_W-1:0];
        REG_BASES_D: lead_bases_r[3] <= pwdata[BASES_W-1:0];
        REG_LEN_A:   lead_len_r[0]   <= pwdata[LEN_W-1:0];
        REG_LEN_B:   lead_len_r[1]   <= pwdata[LEN_W-1:0];
        REG_LEN_C:   lead_len_r[2]   <= pwdata[LEN_W-1:0];
        REG_LEN_D:   lead_len_r[3]   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_BASES_A: prdata = PDATA_W'(lead_bases_r[0]);
      REG_BASES_B: prdata = PDATA_W'(lead_bases_r[1]);
      REG_BASES_C: prdata = PDATA_W'(lead_bases_r[2]);
      REG_BASES_D: prdata = PDATA_W'(lead_bases_r[3]);
      REG_LEN_A:   prdata = PDATA_W'(lead_len_r[0]);
      REG_LEN_B:   prdata = PDATA_W'(lead_len_r[1]);
      REG_LEN_C:   prdata = PDATA_W'(lead_len_r[2]);
      REG_LEN_D:   prdata = PDATA_W'(lead_len_r[3]);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    for (int l = 0; l < NUM_LEADERS; l++) begin
      len_e[l] = eff_len(lead_len_r[l]);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, snap_valid_r, out_valid_r;
  logic s2_last_r;
  logic out_free, snap_move, snap_free, s2_adv, s2_free, s1_adv, s1_free;
  logic in_acc;

  assign out_free  = !out_valid_r || out_ready;
  assign snap_move = snap_valid_r && out_free;
  assign snap_free = !snap_valid_r || snap_move;
  assign s2_adv    = s2_valid_r && (!s2_last_r || snap_free);
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s1_adv;
  assign in_ready  = s1_free;
  assign in_acc    = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Position counter and stage 1 (history shift)
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             hclr_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_last_r, s1_ovf_r;
  logic             pos_at_max;

  assign pos_at_max = (pos_r == POS_MAX);

  // Saturating count; a last base restarts the sequence
  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (in_acc) begin
      if (in_data.last_base) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = pos_at_max ? pos_r : pos_r + POS_W'(1);
        ovf_nxt = ovf_r || pos_at_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      hclr_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
      if (in_acc) begin
        hclr_r     <= in_data.last_base;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r  <= pos_r;
      s1_last_r <= in_data.last_base;
      s1_ovf_r  <= ovf_r || pos_at_max;
    end
  end

  // History cell chain, slot 0 holds the newest base
  logic [CODE_W-1:0]           cell_base [MAX_LEADER_LEN];
  logic [NUM_LEADERS-1:0]      cell_eq   [MAX_LEADER_LEN];

  for (genvar j = 0; j < MAX_LEADER_LEN; j++) begin : g_cell
    logic [NUM_LEADERS-1:0][1:0] exp_j;
    logic [CODE_W-1:0]           src;
    logic                        kill;

    always_comb begin
      for (int l = 0; l < NUM_LEADERS; l++) begin
        exp_j[l] = exp_base(lead_bases_r[l], len_e[l], j);
      end
    end

    if (j == 0) begin : g_head
      assign src  = in_data.base_code;
      assign kill = 1'b0;
    end else begin : g_body
      assign src  = cell_base[j-1];
      assign kill = hclr_r;
    end

    lsm_base_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .kill     (kill),
      .base_in  (src),
      .exp_in   (exp_j),
      .base_out (cell_base[j]),
      .eq       (cell_eq[j])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 2: suffix compares and match starts
  // ---------------------------------------------------------------------
  logic [NUM_LEADERS-1:0]            hit_c     [MAX_TRIM];
  logic [NUM_LEADERS-1:0][POS_W-1:0] start_c   [MAX_TRIM];
  logic [NUM_LEADERS-1:0]            s2_hit_r  [MAX_TRIM];
  logic [NUM_LEADERS-1:0][POS_W-1:0] s2_start_r[MAX_TRIM];
  logic                              s2_ovf_r;

  always_comb begin
    logic             ok;
    logic [LEN_W-1:0] m;
    logic [POS_W:0]   p1;
    p1 = {1'b0, s1_pos_r} + (POS_W+1)'(1);
    for (int t = 0; t < MAX_TRIM; t++) begin
      for (int l = 0; l < NUM_LEADERS; l++) begin
        m  = len_e[l] - LEN_W'(t);
        ok = (len_e[l] > LEN_W'(t));
        for (int j = 0; j < MAX_LEADER_LEN; j++) begin
          if ((LEN_W'(j) < m) && !cell_eq[j][l]) begin
            ok = 1'b0;
          end
        end
        hit_c[t][l]   = ok;
        start_c[t][l] = (p1 >= (POS_W+1)'(m)) ? POS_W'(p1 - (POS_W+1)'(m)) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last_r  <= s1_last_r;
      s2_ovf_r   <= s1_ovf_r;
      s2_hit_r   <= hit_c;
      s2_start_r <= start_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: per-trim best, snapshot at end of sequence
  // ---------------------------------------------------------------------
  trim_ctl_t trim_ctl;
  cand_t     merged [MAX_TRIM];

  assign trim_ctl.upd = s2_adv;
  assign trim_ctl.clr = s2_last_r;

  for (genvar t = 0; t < MAX_TRIM; t++) begin : g_trim
    lsm_trim_cell u_trim (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (trim_ctl),
      .hit_in   (s2_hit_r[t]),
      .start_in (s2_start_r[t]),
      .merged   (merged[t])
    );
  end

  cand_t snap_r [MAX_TRIM];
  logic  snap_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (s2_adv && s2_last_r) begin
      snap_valid_r <= 1'b1;
    end else if (snap_move) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last_r) begin
      snap_r     <= merged;
      snap_ovf_r <= s2_ovf_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: smallest matching trim into the output register
  // ---------------------------------------------------------------------
  out_item_t res_c;
  out_item_t out_data_r;

  always_comb begin
    res_c          = '0;
    res_c.overflow = snap_ovf_r;
    for (int t = MAX_TRIM - 1; t >= 0; t--) begin
      if (snap_r[t].hit) begin
        res_c.found          = 1'b1;
        res_c.leader_index   = snap_r[t].lead;
        res_c.start_position = snap_r[t].start;
        res_c.matched_length = len_e[snap_r[t].lead] - LEN_W'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_data_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/lsm_base_cell.sv -----
// One history cell: holds a base, passes it down the chain, compares it to each leader.
module lsm_base_cell import lsm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic                          kill,
  input  logic [CODE_W-1:0]             base_in,
  input  logic [NUM_LEADERS-1:0][1:0]   exp_in,
  output logic [CODE_W-1:0]             base_out,
  output logic [NUM_LEADERS-1:0]        eq
);

  logic [CODE_W-1:0] base_r;
  logic [CODE_W-1:0] base_nxt;

  // Shift in the neighbor's base; kill drops the previous sequence
  always_comb begin
    base_nxt = base_r;
    if (shift_en) begin
      base_nxt = kill ? CODE_OTHER : base_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= CODE_OTHER;
    end else begin
      base_r <= base_nxt;
    end
  end

  assign base_out = base_r;

  // Codes 4 to 7 never match
  always_comb begin
    for (int l = 0; l < NUM_LEADERS; l++) begin
      eq[l] = !base_r[2] && (base_r[1:0] == exp_in[l]);
    end
  end

endmodule

// ----- rtl/core/lsm_trim_cell.sv -----
// One trim cell: keeps the earliest match over all leaders for one trim amount.
module lsm_trim_cell import lsm_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  trim_ctl_t                           ctl,
  input  logic [NUM_LEADERS-1:0]              hit_in,
  input  logic [NUM_LEADERS-1:0][POS_W-1:0]   start_in,
  output cand_t                               merged
);

  cand_t best_r;
  cand_t best_nxt;
  cand_t cand [NUM_LEADERS];
  cand_t pair_lo;
  cand_t pair_hi;

  // Candidates of this request, one per leader
  always_comb begin
    for (int l = 0; l < NUM_LEADERS; l++) begin
      cand[l].hit   = hit_in[l];
      cand[l].start = start_in[l];
      cand[l].lead  = LEAD_W'(l);
    end
  end

  // Two-level min tree, then against the stored best
  assign pair_lo = better(cand[0], cand[1]);
  assign pair_hi = better(cand[2], cand[3]);
  assign merged  = better(better(pair_lo, pair_hi), best_r);

  always_comb begin
    best_nxt = best_r;
    if (ctl.upd) begin
      best_nxt = ctl.clr ? CAND_RESET : merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= CAND_RESET;
    end else begin
      best_r <= best_nxt;
    end
  end

endmodule
